FILE: hdl/dsss_pkg.sv
package dsss_pkg;

    // Default geometry of the shared store.
    localparam int DEF_STORE_DEPTH = 256;
    localparam int DEF_DATA_WIDTH  = 32;

    // Fixed field widths of the transaction ports.
    localparam int CMD_W    = 2;
    localparam int OUT_W    = 32;
    localparam int FILL_W   = 9;
    localparam int STATUS_W = 2;

    // Command codes. The unused code behaves like CMD_NONE.
    localparam logic [CMD_W-1:0] CMD_NONE = 2'd0;
    localparam logic [CMD_W-1:0] CMD_PUSH = 2'd1;
    localparam logic [CMD_W-1:0] CMD_POP  = 2'd2;

    // Status codes reported with every result.
    localparam logic [STATUS_W-1:0] STAT_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_EMPTY = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_LOAD
    } t_state;

    // Controller to datapath commands.
    typedef struct packed {
        logic capture;
        logic exec;
        logic load_top;
        logic load_out;
    } t_dp_cmd;

    // Datapath to controller status.
    typedef struct packed {
        logic needs_read;
    } t_dp_sts;

endpackage

FILE: hdl/dsss_ctrl.sv
module dsss_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output dsss_pkg::t_dp_cmd o_cmd,
    input  dsss_pkg::t_dp_sts i_sts
);

    dsss_pkg::t_state r_state;
    dsss_pkg::t_state n_state;
    logic             r_out_valid;
    logic             n_out_valid;
    logic             in_ready;

    // A new transaction is taken only when the result slot is free or drains now.
    assign in_ready    = (r_state == dsss_pkg::ST_IDLE) && (!r_out_valid || !i_out_stall);
    assign o_in_stall  = !in_ready;
    assign o_out_valid = r_out_valid;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            dsss_pkg::ST_IDLE: begin
                if (i_in_valid && in_ready) begin
                    n_state = dsss_pkg::ST_EXEC;
                end
            end
            dsss_pkg::ST_EXEC: begin
                n_state = i_sts.needs_read ? dsss_pkg::ST_LOAD : dsss_pkg::ST_IDLE;
            end
            dsss_pkg::ST_LOAD: begin
                n_state = dsss_pkg::ST_IDLE;
            end
            default: begin
                n_state = dsss_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        o_cmd = '0;
        unique case (r_state)
            dsss_pkg::ST_IDLE: begin
                o_cmd.capture = i_in_valid && in_ready;
            end
            dsss_pkg::ST_EXEC: begin
                o_cmd.exec     = 1'b1;
                o_cmd.load_out = !i_sts.needs_read;
            end
            dsss_pkg::ST_LOAD: begin
                o_cmd.load_top = 1'b1;
                o_cmd.load_out = 1'b1;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

    assign n_out_valid = o_cmd.load_out || (r_out_valid && i_out_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= dsss_pkg::ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

FILE: hdl/dsss_dp.sv
module dsss_dp #(
    parameter int STORE_DEPTH = dsss_pkg::DEF_STORE_DEPTH,
    parameter int DATA_WIDTH  = dsss_pkg::DEF_DATA_WIDTH
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  dsss_pkg::t_dp_cmd                   i_cmd,
    output dsss_pkg::t_dp_sts                   o_sts,
    input  logic [dsss_pkg::CMD_W-1:0]          i_cmd_code,
    input  logic                                i_stack_sel,
    input  logic signed [31:0]                  i_push_data,
    output logic signed [dsss_pkg::OUT_W-1:0]   o_top_lower,
    output logic signed [dsss_pkg::OUT_W-1:0]   o_top_upper,
    output logic [dsss_pkg::FILL_W-1:0]         o_fill_lower,
    output logic [dsss_pkg::FILL_W-1:0]         o_fill_upper,
    output logic [dsss_pkg::STATUS_W-1:0]       o_status
);

    localparam int AW    = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
    localparam int CNT_W = $clog2(STORE_DEPTH + 1);
    localparam logic [CNT_W:0]   DEPTH_SUM = (CNT_W + 1)'(STORE_DEPTH);
    localparam logic [CNT_W-1:0] DEPTH_C   = CNT_W'(STORE_DEPTH);
    localparam logic [CNT_W-1:0] ONE_C     = CNT_W'(1);
    localparam logic [CNT_W-1:0] TWO_C     = CNT_W'(2);

    logic [DATA_WIDTH-1:0] r_mem [STORE_DEPTH];
    logic [DATA_WIDTH-1:0] r_rd_data;

    // Captured transaction.
    logic [dsss_pkg::CMD_W-1:0] r_cmd;
    logic                       r_sel;
    logic signed [DATA_WIDTH-1:0] r_data;

    logic [CNT_W-1:0] r_cnt_l, n_cnt_l;
    logic [CNT_W-1:0] r_cnt_u, n_cnt_u;
    logic signed [DATA_WIDTH-1:0] r_top_l, n_top_l;
    logic signed [DATA_WIDTH-1:0] r_top_u, n_top_u;
    logic [dsss_pkg::STATUS_W-1:0] r_status, n_status;

    logic            wr_en;
    logic [AW-1:0]   wr_addr;
    logic            rd_en;
    logic [AW-1:0]   rd_addr;
    logic            full;
    logic [CNT_W-1:0] addr_calc;

    assign full = ({1'b0, r_cnt_l} + {1'b0, r_cnt_u}) >= DEPTH_SUM;

    always_comb begin
        n_cnt_l   = r_cnt_l;
        n_cnt_u   = r_cnt_u;
        n_top_l   = r_top_l;
        n_top_u   = r_top_u;
        n_status  = r_status;
        wr_en     = 1'b0;
        rd_en     = 1'b0;
        addr_calc = '0;
        if (i_cmd.exec) begin
            n_status = dsss_pkg::STAT_OK;
            unique case (r_cmd)
                dsss_pkg::CMD_PUSH: begin
                    if (full) begin
                        n_status = dsss_pkg::STAT_FULL;
                    end else if (r_sel) begin
                        wr_en     = 1'b1;
                        addr_calc = DEPTH_C - r_cnt_u - ONE_C;
                        n_cnt_u   = r_cnt_u + ONE_C;
                        n_top_u   = r_data;
                    end else begin
                        wr_en     = 1'b1;
                        addr_calc = r_cnt_l;
                        n_cnt_l   = r_cnt_l + ONE_C;
                        n_top_l   = r_data;
                    end
                end
                dsss_pkg::CMD_POP: begin
                    if (r_sel) begin
                        if (r_cnt_u == '0) begin
                            n_status = dsss_pkg::STAT_EMPTY;
                        end else begin
                            n_cnt_u = r_cnt_u - ONE_C;
                            if (r_cnt_u != ONE_C) begin
                                rd_en     = 1'b1;
                                addr_calc = DEPTH_C - r_cnt_u + ONE_C;
                            end
                        end
                    end else begin
                        if (r_cnt_l == '0) begin
                            n_status = dsss_pkg::STAT_EMPTY;
                        end else begin
                            n_cnt_l = r_cnt_l - ONE_C;
                            if (r_cnt_l != ONE_C) begin
                                rd_en     = 1'b1;
                                addr_calc = r_cnt_l - TWO_C;
                            end
                        end
                    end
                end
                default: begin
                    n_status = dsss_pkg::STAT_OK;
                end
            endcase
        end
        if (i_cmd.load_top) begin
            if (r_sel) begin
                n_top_u = r_rd_data;
            end else begin
                n_top_l = r_rd_data;
            end
        end
    end

    assign wr_addr          = addr_calc[AW-1:0];
    assign rd_addr          = addr_calc[AW-1:0];
    assign o_sts.needs_read = rd_en;

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= r_data;
        end
        if (rd_en) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_cmd  <= i_cmd_code;
            r_sel  <= i_stack_sel;
            r_data <= DATA_WIDTH'(i_push_data);
        end
        r_top_l  <= n_top_l;
        r_top_u  <= n_top_u;
        r_status <= n_status;
        if (i_cmd.load_out) begin
            o_top_lower  <= (n_cnt_l == '0) ? '0 : dsss_pkg::OUT_W'(n_top_l);
            o_top_upper  <= (n_cnt_u == '0) ? '0 : dsss_pkg::OUT_W'(n_top_u);
            o_fill_lower <= dsss_pkg::FILL_W'(n_cnt_l);
            o_fill_upper <= dsss_pkg::FILL_W'(n_cnt_u);
            o_status     <= n_status;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt_l <= '0;
            r_cnt_u <= '0;
        end else begin
            r_cnt_l <= n_cnt_l;
            r_cnt_u <= n_cnt_u;
        end
    end

endmodule

FILE: hdl/dual_stack_shared_store_core.sv
// Two LIFO stacks that share one store of STORE_DEPTH entries. The lower stack
// grows upward from entry zero and the upper stack grows downward from the last
// entry, so either stack may use all space the other leaves free.
// The input channel carries one transaction per operation: a command (none,
// push or pop), the target stack and the value to push. The output channel
// returns one result per input transaction: the top of each stack (zero when
// that stack is empty), both fill counts and a status that flags a push into a
// full store or a pop on an empty stack. Neither case changes the stacks.
// A push or a no-op passes through the execute state to the result. A pop
// that leaves entries behind also passes through a load state, since the new
// top is read from the registered store port after the fill count moves. The
// store has one write and one read port, and the controller handles one
// transaction at a time, so a new one is taken only back in the idle state.
// The result sits in an output register; the next transaction is accepted as
// soon as that register is free or is being taken, so a stalled receiver only
// holds off new input once a finished result is still waiting.
// Synchronous reset empties both stacks and drops any pending result. The
// store itself is not cleared; only written entries are ever read back.
module dual_stack_shared_store_core #(
    parameter int STORE_DEPTH = dsss_pkg::DEF_STORE_DEPTH,
    parameter int DATA_WIDTH  = dsss_pkg::DEF_DATA_WIDTH
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // Input transaction channel.
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic [dsss_pkg::CMD_W-1:0]        i_cmd,
    input  logic                              i_stack_sel,
    input  logic signed [31:0]                i_push_data,
    // Result transaction channel.
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic signed [dsss_pkg::OUT_W-1:0] o_top_lower,
    output logic signed [dsss_pkg::OUT_W-1:0] o_top_upper,
    output logic [dsss_pkg::FILL_W-1:0]       o_fill_lower,
    output logic [dsss_pkg::FILL_W-1:0]       o_fill_upper,
    output logic [dsss_pkg::STATUS_W-1:0]     o_status
);

    dsss_pkg::t_dp_cmd dp_cmd;
    dsss_pkg::t_dp_sts dp_sts;

    // The controller sequences capture, execution, the top reload after a pop
    // and the result handoff.
    dsss_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_cmd       (dp_cmd),
        .i_sts       (dp_sts)
    );

    // The datapath holds the store, both fill counts, the cached tops and the
    // result register.
    dsss_dp #(
        .STORE_DEPTH (STORE_DEPTH),
        .DATA_WIDTH  (DATA_WIDTH)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (dp_cmd),
        .o_sts        (dp_sts),
        .i_cmd_code   (i_cmd),
        .i_stack_sel  (i_stack_sel),
        .i_push_data  (i_push_data),
        .o_top_lower  (o_top_lower),
        .o_top_upper  (o_top_upper),
        .o_fill_lower (o_fill_lower),
        .o_fill_upper (o_fill_upper),
        .o_status     (o_status)
    );

endmodule

FILE: tb/tb.sv
`timescale 1ns / 1ps

// Self-checking bench for the dual stack core. A mirror of the shared store
// and both fill counts predicts the full result of every operation as the
// input transaction is accepted. The predicted views wait in a queue until
// the core hands back its result transactions, which are compared field by
// field in arrival order.
module tb;

    localparam int DEPTH = dsss_pkg::DEF_STORE_DEPTH;
    localparam int CYCLE_LIMIT = 400000;
    localparam int LONG_HOLD = 300;
    localparam int SETTLE_CYCLES = 10;

    // The fourth command code is unused and must behave like a no-op.
    localparam logic [dsss_pkg::CMD_W-1:0] CMD_SPARE = 2'd3;
    localparam logic STACK_LOWER = 1'b0;
    localparam logic STACK_UPPER = 1'b1;

    // One full result as the core reports it.
    typedef struct packed {
        logic signed [dsss_pkg::OUT_W-1:0] top_lower;
        logic signed [dsss_pkg::OUT_W-1:0] top_upper;
        logic [dsss_pkg::FILL_W-1:0]       fill_lower;
        logic [dsss_pkg::FILL_W-1:0]       fill_upper;
        logic [dsss_pkg::STATUS_W-1:0]     status;
    } t_stack_view;

    logic                              i_clk = 1'b0;
    logic                              i_rst_n = 1'b0;
    logic                              i_in_valid = 1'b0;
    logic                              o_in_stall;
    logic [dsss_pkg::CMD_W-1:0]        i_cmd = dsss_pkg::CMD_NONE;
    logic                              i_stack_sel = STACK_LOWER;
    logic signed [31:0]                i_push_data = '0;
    logic                              o_out_valid;
    logic                              i_out_stall = 1'b0;
    logic signed [dsss_pkg::OUT_W-1:0] o_top_lower;
    logic signed [dsss_pkg::OUT_W-1:0] o_top_upper;
    logic [dsss_pkg::FILL_W-1:0]       o_fill_lower;
    logic [dsss_pkg::FILL_W-1:0]       o_fill_upper;
    logic [dsss_pkg::STATUS_W-1:0]     o_status;

    // Mirror of the core's state.
    logic [31:0] store_mirror [DEPTH];
    int          lower_depth = 0;
    int          upper_depth = 0;

    // Views predicted for accepted operations, oldest first.
    t_stack_view views_pending [$];

    // Idle and stall rates in percent, set per test.
    int sender_idle_pct = 0;
    int receiver_stall_pct = 0;
    bit hold_request = 1'b0;
    int hold_left = 0;

    int mismatch_count = 0;
    int cycle_count = 0;
    int ops_accepted = 0;
    int pushes_stored = 0;
    int pops_done = 0;
    int full_drops = 0;
    int empty_pops = 0;
    int results_seen = 0;

    dual_stack_shared_store_core uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_cmd        (i_cmd),
        .i_stack_sel  (i_stack_sel),
        .i_push_data  (i_push_data),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_top_lower  (o_top_lower),
        .o_top_upper  (o_top_upper),
        .o_fill_lower (o_fill_lower),
        .o_fill_upper (o_fill_upper),
        .o_status     (o_status)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Hard stop in case the core hangs.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d results outstanding",
                     cycle_count, views_pending.size());
            $display("Mismatches found");
            $finish;
        end
    end

    // Result receiver. A requested hold keeps the stall up for a long
    // stretch so the core's output register fills and it backs up its input.
    always @(posedge i_clk) begin
        if (hold_request) begin
            hold_left = LONG_HOLD;
            hold_request = 1'b0;
        end
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(99) < receiver_stall_pct);
        end
    end

    // Apply one operation to the mirror and return the view the core must
    // report afterwards. A push into a full store and a pop on an empty
    // stack leave the mirror untouched and only set the status.
    function automatic t_stack_view predict_stack_view(
        input logic [dsss_pkg::CMD_W-1:0] cmd,
        input logic                       stack_sel,
        input logic [31:0]                data
    );
        t_stack_view view;
        view.status = dsss_pkg::STAT_OK;
        if (cmd == dsss_pkg::CMD_PUSH) begin
            if (lower_depth + upper_depth >= DEPTH) begin
                view.status = dsss_pkg::STAT_FULL;
                full_drops++;
            end else if (stack_sel == STACK_UPPER) begin
                upper_depth++;
                store_mirror[DEPTH - upper_depth] = data;
                pushes_stored++;
            end else begin
                store_mirror[lower_depth] = data;
                lower_depth++;
                pushes_stored++;
            end
        end else if (cmd == dsss_pkg::CMD_POP) begin
            if (stack_sel == STACK_UPPER) begin
                if (upper_depth == 0) begin
                    view.status = dsss_pkg::STAT_EMPTY;
                    empty_pops++;
                end else begin
                    upper_depth--;
                    pops_done++;
                end
            end else begin
                if (lower_depth == 0) begin
                    view.status = dsss_pkg::STAT_EMPTY;
                    empty_pops++;
                end else begin
                    lower_depth--;
                    pops_done++;
                end
            end
        end
        // Only entries within a stack's filled region are looked at, and each was pushed.
        view.top_lower  = (lower_depth == 0) ? '0 : store_mirror[lower_depth - 1];
        view.top_upper  = (upper_depth == 0) ? '0 : store_mirror[DEPTH - upper_depth];
        view.fill_lower = dsss_pkg::FILL_W'(lower_depth);
        view.fill_upper = dsss_pkg::FILL_W'(upper_depth);
        ops_accepted++;
        return view;
    endfunction

    task automatic report_field(input string field, input logic [31:0] want,
                                input logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s expected %h, got %h", $time, field, want, got);
            mismatch_count++;
        end
    endtask

    // Compare each result transaction with the oldest prediction.
    always @(posedge i_clk) begin : check_results
        t_stack_view want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            results_seen++;
            if (views_pending.size() == 0) begin
                $display("%0t: result arrived with no operation outstanding", $time);
                mismatch_count++;
            end else begin
                want = views_pending.pop_front();
                report_field("top_lower", want.top_lower, o_top_lower);
                report_field("top_upper", want.top_upper, o_top_upper);
                report_field("fill_lower", 32'(want.fill_lower), 32'(o_fill_lower));
                report_field("fill_upper", 32'(want.fill_upper), 32'(o_fill_upper));
                report_field("status", 32'(want.status), 32'(o_status));
            end
        end
    end

    // Offer one operation and wait until the core takes it. While the sender
    // idles, the payload carries random junk with valid low.
    task automatic issue_op(input logic [dsss_pkg::CMD_W-1:0] cmd,
                            input logic stack_sel, input logic [31:0] data);
        while ($urandom_range(99) < sender_idle_pct) begin
            i_in_valid  <= 1'b0;
            i_cmd       <= dsss_pkg::CMD_W'($urandom_range(3));
            i_stack_sel <= 1'($urandom_range(1));
            i_push_data <= $urandom;
            @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_cmd       <= cmd;
        i_stack_sel <= stack_sel;
        i_push_data <= data;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        views_pending.push_back(predict_stack_view(cmd, stack_sel, data));
    endtask

    // Drop valid and wait until every predicted result has come back.
    task automatic drain_results();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (views_pending.size() != 0) @(posedge i_clk);
    endtask

    task automatic set_idling(input int send_pct, input int recv_pct);
        sender_idle_pct = send_pct;
        receiver_stall_pct = recv_pct;
    endtask

    // Peeks, the spare code, empty pops and extreme values on both stacks.
    task automatic test_directed_ops();
        issue_op(dsss_pkg::CMD_NONE, STACK_LOWER, 32'h0000_0000);
        issue_op(CMD_SPARE, STACK_UPPER, 32'h1234_5678);
        issue_op(dsss_pkg::CMD_POP, STACK_LOWER, 32'h0000_0000);
        issue_op(dsss_pkg::CMD_POP, STACK_UPPER, 32'hFFFF_FFFF);
        issue_op(dsss_pkg::CMD_PUSH, STACK_LOWER, 32'h7FFF_FFFF);
        issue_op(dsss_pkg::CMD_PUSH, STACK_UPPER, 32'h8000_0000);
        issue_op(dsss_pkg::CMD_NONE, STACK_UPPER, 32'hDEAD_BEEF);
        issue_op(dsss_pkg::CMD_PUSH, STACK_LOWER, 32'hFFFF_FFFF);
        issue_op(dsss_pkg::CMD_PUSH, STACK_UPPER, 32'h0000_0000);
        issue_op(dsss_pkg::CMD_PUSH, STACK_UPPER, 32'h0000_0001);
        issue_op(CMD_SPARE, STACK_LOWER, 32'hAAAA_5555);
        issue_op(dsss_pkg::CMD_POP, STACK_UPPER, 32'h0000_0000);
        issue_op(dsss_pkg::CMD_POP, STACK_LOWER, 32'h0000_0000);
        issue_op(dsss_pkg::CMD_POP, STACK_UPPER, 32'h0000_0000);
        issue_op(dsss_pkg::CMD_POP, STACK_UPPER, 32'h0000_0000);
        issue_op(dsss_pkg::CMD_POP, STACK_UPPER, 32'h0000_0000);
        issue_op(dsss_pkg::CMD_POP, STACK_LOWER, 32'h0000_0000);
        issue_op(dsss_pkg::CMD_POP, STACK_LOWER, 32'h0000_0000);
        issue_op(dsss_pkg::CMD_PUSH, STACK_LOWER, 32'h5555_5555);
        issue_op(dsss_pkg::CMD_PUSH, STACK_UPPER, 32'hAAAA_AAAA);
        issue_op(dsss_pkg::CMD_NONE, STACK_LOWER, $urandom);
        issue_op(dsss_pkg::CMD_POP, STACK_LOWER, 32'h0000_0000);
        issue_op(dsss_pkg::CMD_POP, STACK_UPPER, 32'h0000_0000);
        drain_results();
    endtask

    // Fill the whole store from the lower side, hit the full condition from
    // both sides, hand 100 entries to the upper stack, fill again and then
    // pop both stacks down to empty.
    task automatic test_fill_and_drain();
        int n;
        for (n = 0; n < DEPTH; n++) issue_op(dsss_pkg::CMD_PUSH, STACK_LOWER, $urandom);
        issue_op(dsss_pkg::CMD_PUSH, STACK_UPPER, $urandom);
        issue_op(dsss_pkg::CMD_PUSH, STACK_LOWER, $urandom);
        issue_op(dsss_pkg::CMD_NONE, STACK_UPPER, $urandom);
        for (n = 0; n < 100; n++) issue_op(dsss_pkg::CMD_POP, STACK_LOWER, $urandom);
        for (n = 0; n < 100; n++) issue_op(dsss_pkg::CMD_PUSH, STACK_UPPER, $urandom);
        issue_op(dsss_pkg::CMD_PUSH, STACK_LOWER, $urandom);
        issue_op(dsss_pkg::CMD_PUSH, STACK_UPPER, $urandom);
        while (lower_depth + upper_depth > 0)
            issue_op(dsss_pkg::CMD_POP, 1'($urandom_range(1)), $urandom);
        issue_op(dsss_pkg::CMD_POP, STACK_LOWER, $urandom);
        issue_op(dsss_pkg::CMD_POP, STACK_UPPER, $urandom);
        drain_results();
    endtask

    // The receiver holds off for a long stretch while the sender keeps
    // offering pushes, so the core has to stall its input.
    task automatic test_backpressure();
        int n;
        hold_request = 1'b1;
        for (n = 0; n < 40; n++)
            issue_op((n % 4 == 3) ? dsss_pkg::CMD_POP : dsss_pkg::CMD_PUSH,
                     1'($urandom_range(1)), $urandom);
        drain_results();
    endtask

    // Random operation mix; the push and pop shares steer the fill counts.
    task automatic test_random_mix(input int count, input int push_pct,
                                   input int pop_pct, input int upper_pct);
        int n;
        int roll;
        logic [dsss_pkg::CMD_W-1:0] cmd;
        for (n = 0; n < count; n++) begin
            roll = $urandom_range(99);
            if (roll < push_pct)
                cmd = dsss_pkg::CMD_PUSH;
            else if (roll < push_pct + pop_pct)
                cmd = dsss_pkg::CMD_POP;
            else
                cmd = $urandom_range(1) ? dsss_pkg::CMD_NONE : CMD_SPARE;
            issue_op(cmd, ($urandom_range(99) < upper_pct), $urandom);
        end
        drain_results();
    endtask

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        set_idling(0, 0);
        test_directed_ops();
        set_idling(38, 38);
        test_fill_and_drain();
        set_idling(0, 0);
        test_backpressure();

        set_idling(0, 0);
        test_random_mix(160, 60, 30, 50);
        set_idling(65, 0);
        test_random_mix(160, 45, 45, 70);
        set_idling(0, 65);
        test_random_mix(160, 60, 35, 30);
        set_idling(38, 38);
        test_random_mix(160, 40, 50, 50);

        // Any stray result shows up in the checker during this window.
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        $display("Ran %0d operations, %0d results checked", ops_accepted, results_seen);
        $display("Stored %0d pushes, %0d pops, %0d full drops, %0d empty pops",
                 pushes_stored, pops_done, full_drops, empty_pops);
        if (mismatch_count == 0 && views_pending.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end
endmodule
